### rtl/core/lss_pkg.sv
package lss_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(DEPTH);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH = 3'd0,
    ACT_DUMP = 3'd1,
    ACT_PEEK = 3'd2,
    ACT_SWAP = 3'd3,
    ACT_POP  = 3'd4
  } act_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_PEEK_EMPTY = 3'd1,
    STAT_SWAP_SHORT = 3'd2,
    STAT_POP_EMPTY  = 3'd3,
    STAT_PUSH_FULL  = 3'd4
  } stat_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_SWAP,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] bottom;  // position of the deepest valid entry
  } cell_cmd_t;

endpackage

### rtl/core/lss_if.sv
interface lss_in_if;
  logic                             valid;
  logic                             ready;
  logic [lss_pkg::ACT_W-1:0]        action;
  logic signed [lss_pkg::DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface lss_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [lss_pkg::DATA_W-1:0] data;
  logic [lss_pkg::STAT_W-1:0]       status;
  logic                             last;

  modport source (output valid, output data, output status, output last, input ready);
  modport sink (input valid, input data, input status, input last, output ready);
endinterface

### rtl/core/lss_cell.sv
module lss_cell (
  input  logic                               clk_i,
  input  lss_pkg::cell_cmd_t                 cmd_i,
  input  logic [lss_pkg::IDX_W-1:0]          pos_i,
  input  logic signed [lss_pkg::DATA_W-1:0]  up_i,
  input  logic signed [lss_pkg::DATA_W-1:0]  down_i,
  input  logic signed [lss_pkg::DATA_W-1:0]  wrap_i,
  output logic signed [lss_pkg::DATA_W-1:0]  data_o
);

  logic signed [lss_pkg::DATA_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      lss_pkg::OP_PUSH: data_d = up_i;
      lss_pkg::OP_POP:  data_d = down_i;
      lss_pkg::OP_SWAP: begin
        if (pos_i == lss_pkg::IDX_W'(0)) begin
          data_d = down_i;
        end else if (pos_i == lss_pkg::IDX_W'(1)) begin
          data_d = up_i;
        end
      end
      lss_pkg::OP_ROTATE: begin
        // top moves to the bottom, the rest move one step up
        if (pos_i == cmd_i.bottom) begin
          data_d = wrap_i;
        end else if (pos_i < cmd_i.bottom) begin
          data_d = down_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/core/lifo_stack_with_swap.sv
// a peek or error result is loaded into the output register when the transaction is accepted
// throughput: push, pop, swap and peek are taken one per cycle, back to back, while the output is not stalled
// a dump of n entries holds the input until all n are sent, one entry per cycle from the top,
// paced by the rotation of the cell chain and by the output handshake
// reset: asynchronous, active low; clears fill count, dump state and output valid,
// entry storage is not cleared and is only read below the fill count
module lifo_stack_with_swap (
  input  logic         clk_i,
  input  logic         rst_ni,
  lss_in_if.sink       in_i,
  lss_out_if.source    out_o
);

  localparam int unsigned D = lss_pkg::DEPTH;

  // stack chain, cell 0 holds the top of stack
  logic signed [lss_pkg::DATA_W-1:0] cell_data [D];
  lss_pkg::cell_cmd_t                cmd;

  lss_pkg::state_e                   state_d, state_q;
  logic [lss_pkg::CNT_W-1:0]         count_d, count_q;
  logic [lss_pkg::CNT_W-1:0]         rem_d, rem_q;     // dump entries still to send
  logic [lss_pkg::CNT_W-1:0]         count_m1;

  logic                              out_valid_d, out_valid_q;
  logic signed [lss_pkg::DATA_W-1:0] out_data_d, out_data_q;
  lss_pkg::stat_e                    out_status_d, out_status_q;
  logic                              out_last_d, out_last_q;

  logic                              out_free;
  logic                              accept;
  logic                              emit;

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == lss_pkg::ST_IDLE) && out_free;
  assign accept = in_i.valid && in_i.ready;

  assign count_m1 = count_q - lss_pkg::CNT_W'(1);

  // the chain: each cell sees its upper and lower neighbor, the top wraps for a dump
  for (genvar g = 0; g < D; g++) begin : g_cell
    logic signed [lss_pkg::DATA_W-1:0] up_w, down_w;
    if (g == 0) begin : g_top
      assign up_w = in_i.value;
    end else begin : g_mid
      assign up_w = cell_data[g-1];
    end
    if (g == D - 1) begin : g_bot
      assign down_w = cell_data[g];
    end else begin : g_up
      assign down_w = cell_data[g+1];
    end
    lss_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .pos_i  (lss_pkg::IDX_W'(g)),
      .up_i   (up_w),
      .down_i (down_w),
      .wrap_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

  // control: decode the transaction, drive the chain, load the output register
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    cmd.op       = lss_pkg::OP_HOLD;
    cmd.bottom   = count_m1[lss_pkg::IDX_W-1:0];
    emit         = 1'b0;
    out_data_d   = '0;
    out_status_d = lss_pkg::STAT_OK;
    out_last_d   = 1'b1;

    unique case (state_q)
      lss_pkg::ST_IDLE: begin
        if (accept) begin
          case (lss_pkg::act_e'(in_i.action))
            lss_pkg::ACT_PUSH: begin
              if (count_q == lss_pkg::CNT_W'(D)) begin
                emit         = 1'b1;
                out_status_d = lss_pkg::STAT_PUSH_FULL;
              end else begin
                cmd.op  = lss_pkg::OP_PUSH;
                count_d = count_q + lss_pkg::CNT_W'(1);
              end
            end
            lss_pkg::ACT_DUMP: begin
              // empty stack dumps nothing
              if (count_q != '0) begin
                state_d = lss_pkg::ST_DUMP;
                rem_d   = count_q;
              end
            end
            lss_pkg::ACT_PEEK: begin
              emit = 1'b1;
              if (count_q == '0) begin
                out_status_d = lss_pkg::STAT_PEEK_EMPTY;
              end else begin
                out_data_d = cell_data[0];
              end
            end
            lss_pkg::ACT_SWAP: begin
              if (count_q < lss_pkg::CNT_W'(2)) begin
                emit         = 1'b1;
                out_status_d = lss_pkg::STAT_SWAP_SHORT;
              end else begin
                cmd.op = lss_pkg::OP_SWAP;
              end
            end
            lss_pkg::ACT_POP: begin
              if (count_q == '0) begin
                emit         = 1'b1;
                out_status_d = lss_pkg::STAT_POP_EMPTY;
              end else begin
                cmd.op  = lss_pkg::OP_POP;
                count_d = count_m1;
              end
            end
            default: ;  // unused codes leave everything as is
          endcase
        end
      end
      lss_pkg::ST_DUMP: begin
        // send the top and rotate it to the bottom; after n steps the order is restored
        if (out_free) begin
          emit       = 1'b1;
          out_data_d = cell_data[0];
          out_last_d = (rem_q == lss_pkg::CNT_W'(1));
          cmd.op     = lss_pkg::OP_ROTATE;
          rem_d      = rem_q - lss_pkg::CNT_W'(1);
          if (rem_q == lss_pkg::CNT_W'(1)) begin
            state_d = lss_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = lss_pkg::ST_IDLE;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lss_pkg::ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.data   = out_data_q;
  assign out_o.status = out_status_q;
  assign out_o.last   = out_last_q;

  // fill count never passes the stack depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lss_pkg::CNT_W'(D))
    else $error("fill count above depth");

  // no new transaction is taken during a dump
  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lss_pkg::ST_DUMP |-> !in_i.ready && rem_q != '0 && rem_q <= count_q)
    else $error("dump state inconsistent");

  // an error result is always the only and final result
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != lss_pkg::STAT_OK |-> out_last_q && out_data_q == '0)
    else $error("error result malformed");

  // successful push grows the stack by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.action == lss_pkg::ACT_PUSH && count_q != lss_pkg::CNT_W'(D)
    |=> count_q == $past(count_q) + lss_pkg::CNT_W'(1))
    else $error("push did not grow the stack");

  // dump leaves the fill count untouched
  a_dump_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lss_pkg::ST_DUMP |=> count_q == $past(count_q))
    else $error("fill count changed during dump");

endmodule

### bench/tb_lifo_stack_with_swap.sv
module tb_lifo_stack_with_swap;
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;

  // one result transaction as seen on the output channel
  typedef struct {
    logic signed [DATA_W-1:0] data;
    stat_e                    status;
    logic                     last;
  } stack_result_t;

  localparam int unsigned ACT_CODES = 1 << ACT_W;

  logic clk;
  logic rst_n;

  lss_in_if  in_bus ();
  lss_out_if out_bus ();

  lifo_stack_with_swap uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // shadow stack, bottom at index 0
  logic signed [DATA_W-1:0] shadow_stack [DEPTH];
  int unsigned              shadow_fill;
  stack_result_t            pending_results [$];

  // random idling on both channels, switched off for the last part
  bit idle_on = 1'b1;

  int fail_cnt;
  int sent_cnt;
  int checked_cnt;
  int dump_cnt;
  int full_push_cnt;
  int error_result_cnt;

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // every block input known from time zero
  initial begin
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.action <= ACT_PUSH;
    in_bus.value  <= '0;
  end

  // expected results of one accepted transaction
  function automatic void predict_results(input logic [ACT_W-1:0] act,
                                          input logic signed [DATA_W-1:0] val);
    stack_result_t            r;
    logic signed [DATA_W-1:0] tmp;
    r.data   = '0;
    r.status = STAT_OK;
    r.last   = 1'b1;
    case (act)
      ACT_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          r.status = STAT_PUSH_FULL;
          pending_results.push_back(r);
          full_push_cnt++;
          error_result_cnt++;
        end else begin
          shadow_stack[shadow_fill] = val;
          shadow_fill++;
        end
      end
      ACT_DUMP: begin
        // top first, last flag on the bottom entry
        dump_cnt++;
        for (int k = 0; k < int'(shadow_fill); k++) begin
          r.data = shadow_stack[shadow_fill - 1 - k];
          r.last = (k == int'(shadow_fill) - 1);
          pending_results.push_back(r);
        end
      end
      ACT_PEEK: begin
        if (shadow_fill == 0) begin
          r.status = STAT_PEEK_EMPTY;
          error_result_cnt++;
        end else begin
          r.data = shadow_stack[shadow_fill - 1];
        end
        pending_results.push_back(r);
      end
      ACT_SWAP: begin
        if (shadow_fill < 2) begin
          r.status = STAT_SWAP_SHORT;
          pending_results.push_back(r);
          error_result_cnt++;
        end else begin
          tmp                             = shadow_stack[shadow_fill - 1];
          shadow_stack[shadow_fill - 1]   = shadow_stack[shadow_fill - 2];
          shadow_stack[shadow_fill - 2]   = tmp;
        end
      end
      ACT_POP: begin
        if (shadow_fill == 0) begin
          r.status = STAT_POP_EMPTY;
          pending_results.push_back(r);
          error_result_cnt++;
        end else begin
          shadow_fill--;
        end
      end
      default: begin
        // unused codes leave the stack alone and produce nothing
      end
    endcase
  endfunction

  // one input transaction; valid stays high on return so a follow-up
  // item can go out back to back
  task automatic send_item(input logic [ACT_W-1:0] act,
                           input logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.action <= act;
    in_bus.value  <= val;
    do @(posedge clk); while (!in_bus.ready);
    predict_results(act, val);
    sent_cnt++;
  endtask

  // lower valid at the acceptance edge before any wait
  task automatic release_input();
    in_bus.valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    // a push or pop could still be in flight with nothing expected
    repeat (4) @(posedge clk);
  endtask

  // output side back-pressure in random bursts
  initial begin
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk) begin : result_check
    stack_result_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: data %0d status %0d last %0b",
               out_bus.data, out_bus.status, out_bus.last);
        fail_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_cnt++;
        if (out_bus.data !== exp_r.data) begin
          $error("data: expected %0d, actual %0d", exp_r.data, out_bus.data);
          fail_cnt++;
        end
        if (out_bus.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_bus.status);
          fail_cnt++;
        end
        if (out_bus.last !== exp_r.last) begin
          $error("last: expected %0b, actual %0b", exp_r.last, out_bus.last);
          fail_cnt++;
        end
      end
    end
  end

  // peek, pop, swap and dump on an empty stack, dump gives nothing
  task automatic test_empty_stack();
    send_item(ACT_PEEK, 32'sd7);
    send_item(ACT_POP, -32'sd1);
    send_item(ACT_SWAP, 32'sd0);
    send_item(ACT_DUMP, 32'sd0);
  endtask

  // one entry: swap is still too short, peek and dump, then pop back to empty and pop once more
  task automatic test_single_entry();
    send_item(ACT_PUSH, 32'sh8000_0000);
    send_item(ACT_SWAP, 32'sd0);
    send_item(ACT_PEEK, 32'sd0);
    send_item(ACT_DUMP, 32'sd0);
    send_item(ACT_POP, 32'sd0);
    send_item(ACT_POP, 32'sd0);
  endtask

  // extreme words, swap order and dump order
  task automatic test_extreme_values();
    send_item(ACT_PUSH, 32'sh7fff_ffff);
    send_item(ACT_PUSH, 32'sh8000_0000);
    send_item(ACT_PUSH, 32'sd0);
    send_item(ACT_PUSH, -32'sd1);
    send_item(ACT_SWAP, 32'sd0);
    send_item(ACT_PEEK, 32'sd0);
    send_item(ACT_DUMP, 32'sh5555_5555);
    send_item(ACT_POP, 32'shaaaa_aaaa);
    send_item(ACT_PEEK, 32'sd0);
    send_item(ACT_SWAP, 32'sd0);
    send_item(ACT_DUMP, 32'sd0);
  endtask

  // codes above pop must be ignored whatever the value
  task automatic test_unused_codes();
    for (int code = ACT_POP + 1; code < ACT_CODES; code++)
      send_item(code[ACT_W-1:0], $urandom);
    send_item(ACT_PEEK, 32'sd0);
    send_item(ACT_DUMP, 32'sd0);
  endtask

  // fill to the top, overflow, full dump, drain past the bottom
  task automatic test_full_stack();
    while (shadow_fill < DEPTH) send_item(ACT_PUSH, $urandom);
    send_item(ACT_PUSH, $urandom);
    send_item(ACT_PEEK, 32'sd0);
    send_item(ACT_SWAP, 32'sd0);
    send_item(ACT_PUSH, $urandom);
    send_item(ACT_DUMP, 32'sd0);
    while (shadow_fill > 0) send_item(ACT_POP, $urandom);
    send_item(ACT_POP, $urandom);
  endtask

  // weighted action choice; fill mode climbs toward full, drain toward empty
  function automatic logic [ACT_W-1:0] pick_action(input int mode);
    int r;
    int push_w;
    int pop_w;
    r = $urandom_range(0, 99);
    case (mode)
      0:       begin push_w = 55; pop_w = 12; end
      1:       begin push_w = 15; pop_w = 50; end
      default: begin push_w = 32; pop_w = 30; end
    endcase
    if (r < push_w) return ACT_PUSH;
    r -= push_w;
    if (r < pop_w) return ACT_POP;
    r -= pop_w;
    if (r < 13) return ACT_SWAP;
    if (r < 25) return ACT_PEEK;
    if (r < 31) return ACT_DUMP;
    return logic'($urandom_range(ACT_POP + 1, ACT_CODES - 1)) ? ACT_W'($urandom_range(
           ACT_POP + 1, ACT_CODES - 1)) : ACT_W'(ACT_CODES - 1);
  endfunction

  // random walk over the stack depth with random words
  task automatic test_random_walk(input int n_items);
    int               done;
    int               mode;
    logic [ACT_W-1:0] act;
    done = 0;
    mode = 2;
    while (done < n_items) begin
      if (done % 40 == 0) mode = $urandom_range(0, 2);
      act = pick_action(mode);
      send_item(act, $urandom);
      if (act <= ACT_POP) done++;
    end
  endtask

  // sender holds off until the output side has caught up
  task automatic test_drain_pause();
    repeat (6) send_item(ACT_PUSH, $urandom);
    send_item(ACT_DUMP, 32'sd0);
    wait_all_results();
    send_item(ACT_PEEK, 32'sd0);
    send_item(ACT_SWAP, 32'sd0);
    send_item(ACT_DUMP, 32'sd0);
    wait_all_results();
    test_random_walk(30);
  endtask

  // last stretch fully back to back on both sides
  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_walk(60);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack();
    test_single_entry();
    test_extreme_values();
    test_unused_codes();
    test_full_stack();
    test_random_walk(240);
    test_drain_pause();
    test_back_to_back();
    wait_all_results();
    repeat (8) @(posedge clk);
    $display("sent %0d transactions, checked %0d results", sent_cnt, checked_cnt);
    $display("dumps %0d, error results %0d (full pushes %0d)",
             dump_cnt, error_result_cnt, full_push_cnt);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("lifo_stack_with_swap test passed");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d results never arrived", pending_results.size());
      $display("lifo_stack_with_swap test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #100_000_000;
    $display("lifo_stack_with_swap test failed");
    $finish;
  end

endmodule
